[hdl/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, codes and helpers of the bit string realigning framer.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  // input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_BIT_OFFSET     = 2'd0;
  localparam logic [1:0] REG_BIT_COUNT      = 2'd1;
  localparam logic [1:0] REG_BINARY_TAG     = 2'd2;
  localparam logic [1:0] REG_BIT_BINARY_TAG = 2'd3;

  localparam logic [7:0] BINARY_TAG_RST     = 8'd109;
  localparam logic [7:0] BIT_BINARY_TAG_RST = 8'd77;
  localparam logic [7:0] BYTE_MASK          = 8'hff;

  // header byte positions
  localparam logic [2:0] HDR_TAG  = 3'd0;
  localparam logic [2:0] HDR_LEN3 = 3'd1;
  localparam logic [2:0] HDR_LEN2 = 3'd2;
  localparam logic [2:0] HDR_LEN1 = 3'd3;
  localparam logic [2:0] HDR_LEN0 = 3'd4;
  localparam logic [2:0] HDR_REM  = 3'd5;

  typedef struct packed {
    logic       op;
    logic [7:0] src_byte;
  } brf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       last;
  } brf_out_t;

  // one queued request for the back end: a header or one or two payload bytes
  typedef struct packed {
    logic        is_hdr;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic        two;
    logic        last;
    logic [29:0] count;
    logic [2:0]  rem;
  } brf_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } brf_fifo_status_t;

  function automatic logic [7:0] tail_mask(input logic [2:0] rem);
    logic [7:0] m;
    if (rem == 3'd0) begin
      m = BYTE_MASK;
    end else begin
      m = BYTE_MASK << (4'd8 - {1'b0, rem});
    end
    return m;
  endfunction

endpackage

[hdl/brf_front.sv]
// ----------------------------------------------------------------------------
// brf_front
// Configuration registers, request classification and frame bookkeeping;
// turns each accepted request into at most one queued back-end command.
// ----------------------------------------------------------------------------
module brf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              accept_i,
  input  brf_pkg::brf_in_t  in_i,
  output logic              push_o,
  output brf_pkg::brf_cmd_t cmd_o
);

  logic [31:0] bit_offset_q;
  logic [31:0] bit_count_q;
  logic [7:0]  binary_tag_q;
  logic [7:0]  bit_binary_tag_q;

  logic [7:0]  prev_q, prev_d;
  logic [28:0] skip_q, skip_d;
  logic [29:0] out_left_q, out_left_d;
  logic        have_prev_q, have_prev_d;
  logic        active_q, active_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_offset_q     <= '0;
      bit_count_q      <= '0;
      binary_tag_q     <= brf_pkg::BINARY_TAG_RST;
      bit_binary_tag_q <= brf_pkg::BIT_BINARY_TAG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        brf_pkg::REG_BIT_OFFSET:     bit_offset_q     <= cfg_wdata_i;
        brf_pkg::REG_BIT_COUNT:      bit_count_q      <= cfg_wdata_i;
        brf_pkg::REG_BINARY_TAG:     binary_tag_q     <= cfg_wdata_i[7:0];
        brf_pkg::REG_BIT_BINARY_TAG: bit_binary_tag_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [2:0]  s;
    logic [2:0]  rem;
    logic [7:0]  mask;
    logic [3:0]  used;
    logic [32:0] sum;
    logic [29:0] bytes;
    logic [29:0] ol;
    logic [7:0]  v0, v1;
    logic        e0, e1, fin0;

    s     = bit_offset_q[2:0];
    rem   = bit_count_q[2:0];
    mask  = brf_pkg::tail_mask(rem);
    used  = (rem == 3'd0) ? 4'd8 : {1'b0, rem};
    sum   = {1'b0, bit_count_q} + 33'd7;
    bytes = sum[32:3];
    ol    = out_left_q;
    v0    = '0;
    v1    = '0;
    e0    = 1'b0;
    e1    = 1'b0;
    fin0  = 1'b0;

    prev_d      = prev_q;
    skip_d      = skip_q;
    out_left_d  = out_left_q;
    have_prev_d = have_prev_q;
    active_d    = active_q;
    push_o      = 1'b0;
    cmd_o       = '0;

    if (accept_i) begin
      if (in_i.op == brf_pkg::OP_START) begin
        push_o       = 1'b1;
        cmd_o.is_hdr = 1'b1;
        cmd_o.byte0  = (rem != 3'd0) ? bit_binary_tag_q : binary_tag_q;
        cmd_o.count  = bytes;
        cmd_o.rem    = rem;
        cmd_o.last   = (bytes == '0);
        skip_d       = bit_offset_q[31:3];
        out_left_d   = bytes;
        prev_d       = '0;
        have_prev_d  = 1'b0;
        active_d     = (bytes != '0);
      end else if (active_q && out_left_q != '0) begin
        if (skip_q != '0) begin
          skip_d = skip_q - 29'd1;
        end else begin
          if (s == 3'd0) begin
            e0   = 1'b1;
            v0   = in_i.src_byte;
            fin0 = (ol == 30'd1);
          end else begin
            e0   = have_prev_q;
            v0   = (prev_q << s) | (in_i.src_byte >> (4'd8 - {1'b0, s}));
            fin0 = have_prev_q && (ol == 30'd1);
            if (have_prev_q) begin
              ol = ol - 30'd1;
            end
            if (!fin0) begin
              prev_d      = in_i.src_byte;
              have_prev_d = 1'b1;
              e1 = (ol == 30'd1) && (({1'b0, s} + used) <= 4'd8);
              v1 = in_i.src_byte << s;
            end
          end
          if (fin0) begin
            v0 = v0 & mask;
          end
          if (e1) begin
            v1 = v1 & mask;
          end
          out_left_d = out_left_q - {29'd0, e0} - {29'd0, e1};
          if (fin0 || e1) begin
            active_d = 1'b0;
          end
          push_o     = e0 || e1;
          cmd_o.last = fin0 || e1;
          if (e0) begin
            cmd_o.byte0 = v0;
            cmd_o.byte1 = v1;
            cmd_o.two   = e1;
          end else begin
            cmd_o.byte0 = v1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      skip_q      <= '0;
      out_left_q  <= '0;
      have_prev_q <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      skip_q      <= skip_d;
      out_left_q  <= out_left_d;
      have_prev_q <= have_prev_d;
      active_q    <= active_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q == (out_left_q != '0))
    else $error("frame active flag disagrees with remaining byte count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !cmd_o.is_hdr && cmd_o.two) |-> cmd_o.last)
    else $error("double payload request that does not close the frame");

endmodule

[hdl/brf_queue.sv]
// ----------------------------------------------------------------------------
// brf_queue
// Small request queue between the front and back ends.
// ----------------------------------------------------------------------------
module brf_queue #(
  parameter int unsigned DEPTH = brf_pkg::QUEUE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  brf_pkg::brf_cmd_t         cmd_i,
  input  logic                      pop_i,
  output brf_pkg::brf_cmd_t         head_o,
  output brf_pkg::brf_fifo_status_t status_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  brf_pkg::brf_cmd_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == FULL_CNT);
  assign status_o.empty = (cnt_q == '0);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty queue");

endmodule

[hdl/brf_back.sv]
// ----------------------------------------------------------------------------
// brf_back
// Expands queued requests into framed output bytes, one per cycle while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module brf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  brf_pkg::brf_cmd_t         head_i,
  input  brf_pkg::brf_fifo_status_t status_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output brf_pkg::brf_out_t         out_o
);

  logic [2:0]        idx_q;
  logic              out_valid_q;
  brf_pkg::brf_out_t out_q;
  brf_pkg::brf_out_t cur;
  logic [2:0]        final_idx;
  logic              load;

  always_comb begin
    cur = '0;
    if (head_i.is_hdr) begin
      final_idx     = (head_i.rem != 3'd0) ? brf_pkg::HDR_REM : brf_pkg::HDR_LEN0;
      cur.is_header = 1'b1;
      cur.last      = (idx_q == brf_pkg::HDR_LEN0) && head_i.last;
      case (idx_q)
        brf_pkg::HDR_TAG:  cur.out_byte = head_i.byte0;
        brf_pkg::HDR_LEN3: cur.out_byte = {2'b00, head_i.count[29:24]};
        brf_pkg::HDR_LEN2: cur.out_byte = head_i.count[23:16];
        brf_pkg::HDR_LEN1: cur.out_byte = head_i.count[15:8];
        brf_pkg::HDR_LEN0: cur.out_byte = head_i.count[7:0];
        brf_pkg::HDR_REM:  cur.out_byte = {5'd0, head_i.rem};
        default:           cur.out_byte = '0;
      endcase
    end else begin
      final_idx    = head_i.two ? 3'd1 : 3'd0;
      cur.out_byte = (idx_q == 3'd0) ? head_i.byte0 : head_i.byte1;
      cur.last     = (idx_q == final_idx) && head_i.last;
    end
  end

  assign load  = !status_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o = load && (idx_q == final_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= pop_o ? 3'd0 : idx_q + 3'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 3'd0) |-> !status_i.empty)
    else $error("request expansion in progress with empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= brf_pkg::HDR_REM)
    else $error("byte position beyond header length");

endmodule

[hdl/bitstring_realign_framer.sv]
// ----------------------------------------------------------------------------
// bitstring_realign_framer
// Frames a bit string found at any bit offset of a source byte stream.
// ----------------------------------------------------------------------------
// A start request emits a five or six byte header (tag, 32-bit big-endian
// byte count, used bits of the last byte); source byte requests are dropped
// up to the byte offset, then realigned by the bit offset and emitted MSB
// first with the last byte masked. Input requests are taken one per cycle
// while the QUEUE_DEPTH-entry request queue has room; a start becomes five or
// six output bytes and a source byte zero to two, and the output register
// delivers one byte per cycle unless stalled, so output bandwidth sets the
// sustained rate. Requests pass the queue and then the output register.
module bitstring_realign_framer #(
  parameter int unsigned QUEUE_DEPTH = brf_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  brf_pkg::brf_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output brf_pkg::brf_out_t out_o
);

  brf_pkg::brf_cmd_t         push_cmd;
  brf_pkg::brf_cmd_t         head;
  brf_pkg::brf_fifo_status_t status;
  logic                      push;
  logic                      pop;
  logic                      accept;

  assign in_stall_o = status.full;
  assign accept     = in_valid_i && !status.full;

  brf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_i        (in_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  brf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  brf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
